// ===== rtl/core/wkv_pkg.sv =====
// wkv_pkg: shared types and constants for the word-key byte cipher
// no dependencies; imported by every module of the block except wkv_ram
package wkv_pkg;

	// operation codes carried in the low bits of the input transaction
	typedef enum logic [2:0] {
		OP_KEY    = 3'd0,
		OP_ENC    = 3'd1,
		OP_DEC    = 3'd2,
		OP_READ   = 3'd3,
		OP_REWIND = 3'd4,
		OP_CLEAR  = 3'd5
	} op_t;

	localparam logic [7:0] SEP_SPACE   = 8'h20;
	localparam logic [7:0] SEP_NEWLINE = 8'h0A;

	localparam int HIST_BINS   = 256;
	localparam int HIST_AW     = 8;
	localparam int OUT_DEPTH   = 4;
	localparam int IN_TDATA_W  = 16;
	localparam int OUT_TDATA_W = 48;

	// key stage to histogram stage, one transaction in flight
	typedef struct packed {
		logic       valid;
		op_t        op;
		logic [7:0] data_byte;
		logic [7:0] out_byte;
		logic       key_full;
	} s1_t;

	// one result, out_byte in the low bits
	typedef struct packed {
		logic        key_full;
		logic [31:0] bin_count;
		logic [7:0]  out_byte;
	} result_t;

	localparam int RESULT_W = $bits(result_t);

endpackage

// ===== rtl/core/wkv_ram.sv =====
// wkv_ram: generic single-write, single-read synchronous ram
// registered read data; no package dependency
module wkv_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ===== rtl/core/wkv_key_stage.sv =====
// wkv_key_stage: key word table, word index and cipher position, byte add/subtract
// depends on wkv_pkg and wkv_ram
module wkv_key_stage #(
	parameter int KEY_WORDS = 64
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           accept,
	input  wkv_pkg::op_t   op,
	input  logic [7:0]     data_byte,
	output wkv_pkg::s1_t   s1
);
	import wkv_pkg::*;

	localparam int KIW = (KEY_WORDS > 1) ? $clog2(KEY_WORDS) : 1;
	localparam logic [KIW-1:0] LAST_WORD = KIW'(KEY_WORDS - 1);

	// word being loaded lives in cur_word_q; it is flushed to the table on a separator unless it is the last word
	logic [KIW-1:0] kwi_q, pos_q;
	logic [7:0]     cur_word_q;

	logic           is_sep;
	logic           kt_we;
	logic [7:0]     kt_rdata;

	logic           valid_s1, sel_cur_s1, full_s1;
	op_t            op_s1;
	logic [7:0]     byte_s1, cur_s1;
	logic [7:0]     key_s1;

	assign is_sep = (data_byte == SEP_SPACE) || (data_byte == SEP_NEWLINE);
	assign kt_we  = accept && (op == OP_KEY) && is_sep && (kwi_q != LAST_WORD);

	wkv_ram #(.WIDTH(8), .DEPTH(KEY_WORDS)) u_key_ram (
		.clk   (clk),
		.we    (kt_we),
		.waddr (kwi_q),
		.wdata (cur_word_q),
		.raddr (pos_q),
		.rdata (kt_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kwi_q      <= '0;
			pos_q      <= '0;
			cur_word_q <= '0;
			valid_s1   <= 1'b0;
		end else begin
			valid_s1 <= accept;
			if (accept) begin
				unique case (op)
					OP_KEY: begin
						if (is_sep) begin
							if (kwi_q != LAST_WORD) begin
								kwi_q      <= kwi_q + KIW'(1);
								cur_word_q <= '0;
							end
						end else begin
							cur_word_q <= cur_word_q + data_byte;
						end
					end
					OP_ENC, OP_DEC: begin
						// position never exceeds the word index, so wrap at the word in use
						pos_q <= (pos_q == kwi_q) ? '0 : pos_q + KIW'(1);
					end
					OP_REWIND: begin
						pos_q <= '0;
					end
					OP_CLEAR: begin
						kwi_q      <= '0;
						pos_q      <= '0;
						cur_word_q <= '0;
					end
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		op_s1      <= op;
		byte_s1    <= data_byte;
		full_s1    <= (op == OP_KEY) && is_sep && (kwi_q == LAST_WORD);
		sel_cur_s1 <= (pos_q == kwi_q);
		cur_s1     <= cur_word_q;
	end

	assign key_s1 = sel_cur_s1 ? cur_s1 : kt_rdata;

	always_comb begin
		s1.valid     = valid_s1;
		s1.op        = op_s1;
		s1.data_byte = byte_s1;
		s1.key_full  = full_s1;
		case (op_s1)
			OP_ENC:  s1.out_byte = byte_s1 + key_s1;
			OP_DEC:  s1.out_byte = byte_s1 - key_s1;
			default: s1.out_byte = '0;
		endcase
	end
endmodule

// ===== rtl/core/wkv_hist.sv =====
// wkv_hist: ciphertext histogram, saturating read-modify-write with write forwarding
// depends on wkv_pkg and wkv_ram
module wkv_hist #(
	parameter int COUNT_WIDTH = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [7:0]       stat_char,
	input  wkv_pkg::s1_t     s1,
	output logic             push,
	output wkv_pkg::result_t result,
	output logic             busy_s2
);
	import wkv_pkg::*;

	localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

	logic [HIST_AW-1:0]     rd_addr;
	logic [COUNT_WIDTH-1:0] h_rdata;

	logic                   valid_s2, inc_s2, clr_s2, full_s2;
	op_t                    op_s2;
	logic [HIST_AW-1:0]     addr_s2;
	logic [7:0]             byte_s2;

	logic [HIST_BINS-1:0]   bin_ok_q;
	logic                   lw_valid_q;
	logic [HIST_AW-1:0]     lw_addr_q;
	logic [COUNT_WIDTH-1:0] lw_data_q;

	logic [COUNT_WIDTH-1:0] cnt, cnt_next;
	logic [63:0]            cnt_ext;
	logic                   h_we;

	assign rd_addr = (s1.op == OP_READ) ? s1.data_byte : s1.out_byte;

	wkv_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(HIST_BINS)) u_hist_ram (
		.clk   (clk),
		.we    (h_we),
		.waddr (addr_s2),
		.wdata (cnt_next),
		.raddr (rd_addr),
		.rdata (h_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= s1.valid;
		end
	end

	always_ff @(posedge clk) begin
		op_s2   <= s1.op;
		addr_s2 <= rd_addr;
		byte_s2 <= s1.out_byte;
		full_s2 <= s1.key_full;
		inc_s2  <= (s1.op == OP_ENC) && (s1.data_byte == stat_char);
		clr_s2  <= (s1.op == OP_CLEAR);
	end

	// the write of the item just ahead lands on the same edge as this read
	always_comb begin
		if (lw_valid_q && (lw_addr_q == addr_s2)) begin
			cnt = lw_data_q;
		end else if (bin_ok_q[addr_s2]) begin
			cnt = h_rdata;
		end else begin
			cnt = '0;
		end
	end

	assign cnt_next = (cnt == CNT_MAX) ? cnt : cnt + COUNT_WIDTH'(1);
	assign h_we     = valid_s2 && inc_s2;
	assign cnt_ext  = 64'(cnt);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bin_ok_q   <= '0;
			lw_valid_q <= 1'b0;
		end else if (valid_s2 && clr_s2) begin
			bin_ok_q   <= '0;
			lw_valid_q <= 1'b0;
		end else if (h_we) begin
			bin_ok_q[addr_s2] <= 1'b1;
			lw_valid_q        <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (h_we) begin
			lw_addr_q <= addr_s2;
			lw_data_q <= cnt_next;
		end
	end

	assign push             = valid_s2;
	assign busy_s2          = valid_s2;
	assign result.out_byte  = byte_s2;
	assign result.key_full  = full_s2;
	assign result.bin_count = (op_s2 == OP_READ) ? cnt_ext[31:0] : 32'd0;
endmodule

// ===== rtl/core/wkv_out_fifo.sv =====
// wkv_out_fifo: small result queue that decouples the pipeline from the output stall
// depends on wkv_pkg
module wkv_out_fifo #(
	parameter int WIDTH = 41,
	parameter int DEPTH = 4
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push,
	input  logic [WIDTH-1:0]             wdata,
	input  logic                         pop,
	output logic [WIDTH-1:0]             rdata,
	output logic [$clog2(DEPTH+1)-1:0]   level
);
	import wkv_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int LW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [LW-1:0]    level_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			level_q <= level_q + LW'(push) - LW'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= wdata;
		end
	end

	assign rdata = slot_q[rd_ptr_q];
	assign level = level_q;
endmodule

// ===== rtl/core/word_key_vigenere_byte_cipher.sv =====
// word_key_vigenere_byte_cipher: top level of the word-key byte cipher with histogram
// path: a result reaches m_tvalid through the key stage, the histogram stage and the result queue
// throughput: one transaction per cycle while s_tready is high, set by the key ram read and the
// single histogram read-modify-write per cycle (forwarded, no interlock stall)
// reset: arst_n clears indexes, pipeline and queue; ram contents are masked, no clearing pass
// depends on wkv_pkg, wkv_key_stage, wkv_hist, wkv_out_fifo, wkv_ram
module word_key_vigenere_byte_cipher #(
	parameter int KEY_WORDS   = 64,
	parameter int COUNT_WIDTH = 32
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// input transaction
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [wkv_pkg::IN_TDATA_W-1:0]  s_tdata,  // op [2:0], data_byte [10:3]
	// result transaction
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [wkv_pkg::OUT_TDATA_W-1:0] m_tdata,  // out_byte [7:0], bin_count [39:8], key_full [40]
	// stat_char register
	input  logic                            cfg_we,
	input  logic [7:0]                      cfg_wdata
);
	import wkv_pkg::*;

	localparam int LW = $clog2(OUT_DEPTH + 1);

	logic [7:0]    stat_char_q;
	logic          accept;
	op_t           in_op;
	logic [7:0]    in_byte;
	s1_t           s1;
	logic          push, busy_s2;
	result_t       res_s2;
	logic [RESULT_W-1:0] fifo_rdata;
	logic [LW-1:0] level;
	logic [LW:0]   reserved;

	// the user must write configuration only while idle; the block does not enforce it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stat_char_q <= '0;
		end else if (cfg_we) begin
			stat_char_q <= cfg_wdata;
		end
	end

	assign in_op   = op_t'(s_tdata[2:0]);
	assign in_byte = s_tdata[10:3];

	// every transaction in flight has a queue slot reserved, so the pipeline never stalls
	assign reserved = {1'b0, level} + (LW + 1)'(s1.valid) + (LW + 1)'(busy_s2);
	assign s_tready = (reserved < (LW + 1)'(OUT_DEPTH));
	assign accept   = s_tvalid && s_tready;

	// stage 0/1: key words, position, add or subtract
	wkv_key_stage #(.KEY_WORDS(KEY_WORDS)) u_key (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.op        (in_op),
		.data_byte (in_byte),
		.s1        (s1)
	);

	// stage 2: histogram update and bin read
	wkv_hist #(.COUNT_WIDTH(COUNT_WIDTH)) u_hist (
		.clk       (clk),
		.arst_n    (arst_n),
		.stat_char (stat_char_q),
		.s1        (s1),
		.push      (push),
		.result    (res_s2),
		.busy_s2   (busy_s2)
	);

	// result queue feeding the master side
	wkv_out_fifo #(.WIDTH(RESULT_W), .DEPTH(OUT_DEPTH)) u_out (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (res_s2),
		.pop    (m_tvalid && m_tready),
		.rdata  (fifo_rdata),
		.level  (level)
	);

	assign m_tvalid = (level != '0);
	assign m_tdata  = {(OUT_TDATA_W - RESULT_W)'(0), fifo_rdata};
endmodule
